/* design/nrb_pkg.sv */
// Shared types, constants and arithmetic helpers for the Newton basin pixel unit.
package nrb_pkg;

	localparam int FRAME_WIDTH_DEF = 1024;
	localparam int FRAME_HEIGHT_DEF = 1024;
	localparam int MAX_DEGREE_DEF = 8;

	localparam int WIDE_W = 63;
	localparam int WMAG_W = 61;
	localparam logic signed [63:0] WIDE_MAX = 64'sh1FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] NARROW_MAX = 64'sd2147483647;
	localparam logic signed [63:0] NARROW_MIN = -64'sd2147483648;
	localparam logic signed [WIDE_W-1:0] ONE_Q16 = 63'sd65536;

	localparam int DIV_NUM_W = 62;
	localparam int DIV_DEN_W = 61;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam int CORDIC_STEPS = 31;
	localparam int CORDIC_W = 36;

	typedef enum logic [2:0] {
		REG_START_REAL = 3'd0,
		REG_START_IMAG = 3'd1,
		REG_PIXEL_STEP = 3'd2,
		REG_ROOT_COUNT = 3'd3,
		REG_ITER_LIMIT = 3'd4,
		REG_TOLERANCE  = 3'd5
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PLOOP,
		ST_MA,
		ST_MB,
		ST_MC,
		ST_NORM,
		ST_DSQ1,
		ST_DSQ2,
		ST_DCHK,
		ST_RR_GO,
		ST_RR_WAIT,
		ST_RI_GO,
		ST_RI_WAIT,
		ST_SUB,
		ST_NR_GO,
		ST_NR_WAIT,
		ST_NI_GO,
		ST_NI_WAIT,
		ST_CONV1,
		ST_CONV2,
		ST_SINIT,
		ST_SSTEP,
		ST_SMUL,
		ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PINIT,
		OP_MUL_A,
		OP_MUL_B,
		OP_MUL_C,
		OP_NORM_INIT,
		OP_NORM,
		OP_DSQ1,
		OP_DSQ2,
		OP_ZDER,
		OP_DIV_START,
		OP_DIV_TAKE,
		OP_SUB,
		OP_CONV1,
		OP_UPDATE,
		OP_SEC_INIT,
		OP_SEC_STEP,
		OP_SEC_MUL,
		OP_OUT_LOAD
	} op_t;

	typedef enum logic [1:0] {
		DSEL_RECR,
		DSEL_RECI,
		DSEL_NR,
		DSEL_NI
	} dsel_t;

	typedef struct packed {
		op_t   op;
		dsel_t dsel;
	} cmd_t;

	typedef struct packed {
		logic at_limit;
		logic pow_done;
		logic term_last;
		logic norm_done;
		logic d_zero;
		logic div_done;
		logic converged;
		logic sec_last;
	} status_t;

	function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [63:0] v);
		logic signed [WIDE_W-1:0] r;
		if (v > WIDE_MAX) r = WIDE_W'(WIDE_MAX);
		else if (v < -WIDE_MAX) r = WIDE_W'(-WIDE_MAX);
		else r = WIDE_W'(v);
		return r;
	endfunction

	function automatic logic signed [31:0] sat_narrow(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > NARROW_MAX) r = 32'(NARROW_MAX);
		else if (v < NARROW_MIN) r = 32'(NARROW_MIN);
		else r = 32'(v);
		return r;
	endfunction

	function automatic logic [WMAG_W-1:0] wide_mag(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] t;
		t = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		return t[WMAG_W-1:0];
	endfunction

	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

/* design/newton_root_basin_pixel_unit.sv */
// Top level: Newton basin of z^n - 1 for one pixel per word.
// Each iteration computes four quotients in the shared bit-serial divider. One pixel is in flight
// at a time; the next word is taken once the result sits in the output register. Reset clears the
// controller and loads the register defaults.
module newton_root_basin_pixel_unit import nrb_pkg::*; #(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  iterations,
	output logic [2:0]  root_index
);

	cmd_t    cmd;
	status_t st;

	nrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_stall(out_stall),
		.st       (st),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	nrb_dpath #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT),
		.MAX_DEGREE  (MAX_DEGREE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cmd       (cmd),
		.st        (st),
		.iterations(iterations),
		.root_index(root_index)
	);

endmodule

/* design/nrb_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module nrb_div import nrb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo,
	output logic                 done
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quo = quo_q;
	assign done = done_q;

endmodule

/* design/nrb_dpath.sv */
// Datapath: configuration, complex power, reciprocal, Newton update and CORDIC sector.
module nrb_dpath import nrb_pkg::*; #(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	input  cmd_t        cmd,
	output status_t     st,
	output logic [9:0]  iterations,
	output logic [2:0]  root_index
);

	logic signed [31:0] start_real_q;
	logic signed [31:0] start_imag_q;
	logic [24:0]        pixel_step_q;
	logic [3:0]         root_count_q;
	logic [9:0]         limit_q;
	logic [15:0]        tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_real_q <= -32'sd32768000;
			start_imag_q <= -32'sd32768000;
			pixel_step_q <= 25'd65536;
			root_count_q <= 4'd5;
			limit_q <= 10'd50;
			tol_q <= 16'd66;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_REAL: start_real_q <= cfg_data;
				REG_START_IMAG: start_imag_q <= cfg_data;
				REG_PIXEL_STEP: pixel_step_q <= cfg_data[24:0];
				REG_ROOT_COUNT: root_count_q <= cfg_data[3:0];
				REG_ITER_LIMIT: limit_q <= cfg_data[9:0];
				REG_TOLERANCE: tol_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [3:0] n_val;

	always_comb begin
		if (root_count_q == 4'd0) n_val = 4'd1;
		else if (5'(root_count_q) > 5'(MAX_DEGREE)) n_val = 4'(MAX_DEGREE);
		else n_val = root_count_q;
	end

	logic [9:0]         px_c, py_c;
	logic [34:0]        offx, offy;
	logic signed [36:0] sumx, sumy;

	assign px_c = (13'(pixel_x) > 13'(FRAME_WIDTH - 1)) ? 10'(FRAME_WIDTH - 1) : pixel_x;
	assign py_c = (13'(pixel_y) > 13'(FRAME_HEIGHT - 1)) ? 10'(FRAME_HEIGHT - 1) : pixel_y;
	assign offx = 35'(px_c) * 35'(pixel_step_q);
	assign offy = 35'(py_c) * 35'(pixel_step_q);
	assign sumx = 37'(start_real_q) + $signed({2'b00, offx});
	assign sumy = 37'(start_imag_q) + $signed({2'b00, offy});

	logic signed [31:0]       zr_q, zi_q;
	logic signed [WIDE_W-1:0] pr_q, pi_q, ta_q, tb_q;
	logic [63:0]              plo_q;
	logic [92:0]              prod_q;
	logic [WMAG_W-1:0]        mr_q, mi_q;
	logic [59:0]              sq_q;
	logic [60:0]              d_q;
	logic signed [WIDE_W-1:0] wr_q, wi_q, vr_q, vi_q, dzr_q, dzi_q;
	logic [31:0]              sqr_q, sqi_q, tol2_q;
	logic                     small_q;
	logic signed [CORDIC_W-1:0] cx_q, cy_q;
	logic [31:0]              cacc_q;
	logic                     origin_q, skip_q;
	logic [9:0]               res_iter_q, iter_out_q;
	logic [2:0]               res_root_q, root_out_q;

	logic [9:0] depth_q;
	logic [3:0] kcnt_q;
	logic [1:0] j_q;
	logic [5:0] s_q;
	logic [4:0] step_q;

	logic signed [WIDE_W-1:0] wide_a;
	logic signed [31:0]       z_b;
	logic [WMAG_W-1:0]        am;
	logic [31:0]              bm;
	logic [60:0]              phi;
	logic [76:0]              rsh;
	logic [WMAG_W-1:0]        rs;
	logic signed [WIDE_W-1:0] term;

	assign wide_a = j_q[0] ? pi_q : pr_q;
	assign z_b = (j_q[0] ^ j_q[1]) ? zi_q : zr_q;
	assign am = wide_mag(wide_a);
	assign bm = z_b[31] ? 32'(-z_b) : 32'(z_b);
	assign phi = 61'(am[60:32]) * 61'(bm);
	assign rsh = prod_q[92:16];
	assign rs = (|rsh[76:61]) ? WMAG_W'(WIDE_MAX) : rsh[60:0];
	assign term = (wide_a[WIDE_W-1] ^ z_b[31]) ? -$signed({2'b00, rs}) : $signed({2'b00, rs});

	logic [5:0]           e_val;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] div_quo;
	logic                 div_done;
	logic [WMAG_W-1:0]    qs;

	assign e_val = 6'd32 - s_q;

	always_comb begin
		case (cmd.dsel)
			DSEL_RECR: begin
				div_num = DIV_NUM_W'(mr_q[29:0]) << e_val;
				div_den = d_q;
			end
			DSEL_RECI: begin
				div_num = DIV_NUM_W'(mi_q[29:0]) << e_val;
				div_den = d_q;
			end
			DSEL_NR: begin
				div_num = DIV_NUM_W'(wide_mag(vr_q));
				div_den = DIV_DEN_W'(n_val);
			end
			default: begin
				div_num = DIV_NUM_W'(wide_mag(vi_q));
				div_den = DIV_DEN_W'(n_val);
			end
		endcase
	end

	nrb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.op == OP_DIV_START),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	assign qs = div_quo[DIV_NUM_W-1] ? WMAG_W'(WIDE_MAX) : div_quo[WMAG_W-1:0];

	logic [WMAG_W-1:0]          ar, ai;
	logic signed [CORDIC_W-1:0] cdx, cdy;
	logic [35:0]                sec_prod;

	assign ar = wide_mag(dzr_q);
	assign ai = wide_mag(dzi_q);
	assign cdx = cy_q >>> step_q;
	assign cdy = cx_q >>> step_q;
	assign sec_prod = 36'(cacc_q) * 36'(n_val);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				zr_q <= sat_narrow(64'(sumx));
				zi_q <= sat_narrow(64'(sumy));
			end
			OP_PINIT: begin
				pr_q <= ONE_Q16;
				pi_q <= '0;
			end
			OP_MUL_A: plo_q <= 64'(am[31:0]) * 64'(bm);
			OP_MUL_B: prod_q <= 93'({phi, 32'b0}) + 93'(plo_q);
			OP_MUL_C: begin
				case (j_q)
					2'd0: ta_q <= term;
					2'd1: ta_q <= sat_wide(64'(ta_q) - 64'(term));
					2'd2: tb_q <= term;
					default: begin
						pr_q <= ta_q;
						pi_q <= sat_wide(64'(tb_q) + 64'(term));
					end
				endcase
			end
			OP_NORM_INIT: begin
				mr_q <= wide_mag(pr_q);
				mi_q <= wide_mag(pi_q);
			end
			OP_NORM: begin
				mr_q <= mr_q >> 1;
				mi_q <= mi_q >> 1;
			end
			OP_DSQ1: sq_q <= 60'(mr_q[29:0]) * 60'(mr_q[29:0]);
			OP_DSQ2: d_q <= 61'(sq_q) + 61'(60'(mi_q[29:0]) * 60'(mi_q[29:0]));
			OP_ZDER: begin
				res_iter_q <= limit_q;
				res_root_q <= '0;
			end
			OP_DIV_TAKE: begin
				case (cmd.dsel)
					DSEL_RECR: wr_q <= pr_q[WIDE_W-1] ? -$signed({2'b00, qs})
						: $signed({2'b00, qs});
					DSEL_RECI: wi_q <= pi_q[WIDE_W-1] ? $signed({2'b00, qs})
						: -$signed({2'b00, qs});
					DSEL_NR: dzr_q <= vr_q[WIDE_W-1] ? -$signed({2'b00, qs})
						: $signed({2'b00, qs});
					default: dzi_q <= vi_q[WIDE_W-1] ? -$signed({2'b00, qs})
						: $signed({2'b00, qs});
				endcase
			end
			OP_SUB: begin
				vr_q <= sat_wide(64'(zr_q) - 64'(wr_q));
				vi_q <= sat_wide(64'(zi_q) - 64'(wi_q));
			end
			OP_CONV1: begin
				small_q <= (ar < WMAG_W'(tol_q)) && (ai < WMAG_W'(tol_q));
				sqr_q <= 32'(ar[15:0]) * 32'(ar[15:0]);
				sqi_q <= 32'(ai[15:0]) * 32'(ai[15:0]);
				tol2_q <= 32'(tol_q) * 32'(tol_q);
			end
			OP_UPDATE: begin
				zr_q <= sat_narrow(64'(zr_q) - 64'(dzr_q));
				zi_q <= sat_narrow(64'(zi_q) - 64'(dzi_q));
			end
			OP_SEC_INIT: begin
				origin_q <= (zr_q == 32'sd0) && (zi_q == 32'sd0);
				skip_q <= (zr_q == 32'sd0) || (zi_q == 32'sd0);
				if (zr_q > 32'sd0) begin
					cx_q <= CORDIC_W'(zr_q);
					cy_q <= CORDIC_W'(zi_q);
				end else begin
					cx_q <= -CORDIC_W'(zr_q);
					cy_q <= -CORDIC_W'(zi_q);
				end
				if (zi_q == 32'sd0) cacc_q <= (zr_q < 32'sd0) ? 32'h0 : 32'h8000_0000;
				else if (zr_q == 32'sd0) cacc_q <= (zi_q < 32'sd0) ? 32'h4000_0000 : 32'hC000_0000;
				else cacc_q <= (zr_q > 32'sd0) ? 32'h8000_0000 : 32'h0;
			end
			OP_SEC_STEP: begin
				if (!skip_q) begin
					if (!cy_q[CORDIC_W-1]) begin
						cx_q <= cx_q + cdx;
						cy_q <= cy_q - cdy;
						cacc_q <= cacc_q + atan_lut(step_q);
					end else begin
						cx_q <= cx_q - cdx;
						cy_q <= cy_q + cdy;
						cacc_q <= cacc_q - atan_lut(step_q);
					end
				end
			end
			OP_SEC_MUL: begin
				res_iter_q <= depth_q;
				res_root_q <= origin_q ? 3'(n_val >> 1) : sec_prod[34:32];
			end
			OP_OUT_LOAD: begin
				iter_out_q <= res_iter_q;
				root_out_q <= res_root_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			kcnt_q <= '0;
			j_q <= '0;
			s_q <= '0;
			step_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: depth_q <= '0;
				OP_PINIT: begin
					kcnt_q <= 4'd1;
					j_q <= '0;
				end
				OP_MUL_C: begin
					j_q <= j_q + 1'b1;
					if (j_q == 2'd3) kcnt_q <= kcnt_q + 1'b1;
				end
				OP_NORM_INIT: s_q <= '0;
				OP_NORM: s_q <= s_q + 1'b1;
				OP_UPDATE: depth_q <= depth_q + 1'b1;
				OP_SEC_INIT: step_q <= '0;
				OP_SEC_STEP: step_q <= step_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign st.at_limit = depth_q == limit_q;
	assign st.pow_done = kcnt_q >= n_val;
	assign st.term_last = j_q == 2'd3;
	assign st.norm_done = ~|(mr_q[WMAG_W-1:30] | mi_q[WMAG_W-1:30]);
	assign st.d_zero = d_q == '0;
	assign st.div_done = div_done;
	assign st.converged = small_q && ((33'(sqr_q) + 33'(sqi_q)) < 33'(tol2_q));
	assign st.sec_last = step_q == 5'(CORDIC_STEPS - 1);

	assign iterations = iter_out_q;
	assign root_index = root_out_q;

endmodule

/* design/nrb_ctrl.sv */
// Controller state machine that sequences the datapath for one pixel.
module nrb_ctrl import nrb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_stall,
	input  status_t st,
	output logic    in_stall,
	output logic    out_valid,
	output cmd_t    cmd
);

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   fin_fire;

	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (fin_fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_CHECK;
			ST_CHECK: state_nx = st.at_limit ? ST_SINIT : ST_PLOOP;
			ST_PLOOP: state_nx = st.pow_done ? ST_NORM : ST_MA;
			ST_MA: state_nx = ST_MB;
			ST_MB: state_nx = ST_MC;
			ST_MC: state_nx = st.term_last ? ST_PLOOP : ST_MA;
			ST_NORM: if (st.norm_done) state_nx = ST_DSQ1;
			ST_DSQ1: state_nx = ST_DSQ2;
			ST_DSQ2: state_nx = ST_DCHK;
			ST_DCHK: state_nx = st.d_zero ? ST_FIN : ST_RR_GO;
			ST_RR_GO: state_nx = ST_RR_WAIT;
			ST_RR_WAIT: if (st.div_done) state_nx = ST_RI_GO;
			ST_RI_GO: state_nx = ST_RI_WAIT;
			ST_RI_WAIT: if (st.div_done) state_nx = ST_SUB;
			ST_SUB: state_nx = ST_NR_GO;
			ST_NR_GO: state_nx = ST_NR_WAIT;
			ST_NR_WAIT: if (st.div_done) state_nx = ST_NI_GO;
			ST_NI_GO: state_nx = ST_NI_WAIT;
			ST_NI_WAIT: if (st.div_done) state_nx = ST_CONV1;
			ST_CONV1: state_nx = ST_CONV2;
			ST_CONV2: state_nx = st.converged ? ST_SINIT : ST_CHECK;
			ST_SINIT: state_nx = ST_SSTEP;
			ST_SSTEP: if (st.sec_last) state_nx = ST_SMUL;
			ST_SMUL: state_nx = ST_FIN;
			ST_FIN: if (fin_fire) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		cmd.dsel = DSEL_RECR;
		case (state_q)
			ST_IDLE: if (in_valid) cmd.op = OP_LOAD;
			ST_CHECK: if (!st.at_limit) cmd.op = OP_PINIT;
			ST_PLOOP: if (st.pow_done) cmd.op = OP_NORM_INIT;
			ST_MA: cmd.op = OP_MUL_A;
			ST_MB: cmd.op = OP_MUL_B;
			ST_MC: cmd.op = OP_MUL_C;
			ST_NORM: if (!st.norm_done) cmd.op = OP_NORM;
			ST_DSQ1: cmd.op = OP_DSQ1;
			ST_DSQ2: cmd.op = OP_DSQ2;
			ST_DCHK: if (st.d_zero) cmd.op = OP_ZDER;
			ST_RR_GO: cmd.op = OP_DIV_START;
			ST_RR_WAIT: if (st.div_done) cmd.op = OP_DIV_TAKE;
			ST_RI_GO: begin
				cmd.op = OP_DIV_START;
				cmd.dsel = DSEL_RECI;
			end
			ST_RI_WAIT: begin
				cmd.dsel = DSEL_RECI;
				if (st.div_done) cmd.op = OP_DIV_TAKE;
			end
			ST_SUB: cmd.op = OP_SUB;
			ST_NR_GO: begin
				cmd.op = OP_DIV_START;
				cmd.dsel = DSEL_NR;
			end
			ST_NR_WAIT: begin
				cmd.dsel = DSEL_NR;
				if (st.div_done) cmd.op = OP_DIV_TAKE;
			end
			ST_NI_GO: begin
				cmd.op = OP_DIV_START;
				cmd.dsel = DSEL_NI;
			end
			ST_NI_WAIT: begin
				cmd.dsel = DSEL_NI;
				if (st.div_done) cmd.op = OP_DIV_TAKE;
			end
			ST_CONV1: cmd.op = OP_CONV1;
			ST_CONV2: if (!st.converged) cmd.op = OP_UPDATE;
			ST_SINIT: cmd.op = OP_SEC_INIT;
			ST_SSTEP: cmd.op = OP_SEC_STEP;
			ST_SMUL: cmd.op = OP_SEC_MUL;
			ST_FIN: if (fin_fire) cmd.op = OP_OUT_LOAD;
			default: ;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
